// ----- src/r2fft_pkg.sv -----
package r2fft_pkg;

    // One complex word as held in the sample store: imaginary part in the upper half.
    typedef struct packed {
        logic signed [31:0] im;
        logic signed [31:0] re;
    } t_cplx;

    // Butterfly datapath controls from the sequencer.
    typedef struct packed {
        logic load_a;
        logic mul_en;
        logic sum_en;
        logic bypass;
        logic inverse;
    } t_bf_ctrl;

endpackage

// ----- src/radix2_fft_ifft_core.sv -----
// Frame-based radix-2 decimation-in-time FFT/IFFT. Push transactions load 2^log2_points
// complex samples into a single-port-pair sample RAM; the last push starts the transform,
// during which the input is stalled: a bit-reversal pass that reads every index and, for
// each swapped pair, also reads the partner and writes both back, then (N/2)*log2(N)
// butterflies, paced by the one read and one write port of the sample RAM (two reads,
// two writes per butterfly). A push is written straight into the RAM; a pull goes through a
// RAM read, then the optional 1/N rounded shift of the inverse mode into the output
// register, and the input also stalls while a result waits in the output register. Length
// and mode are latched at the start of each transform. There is no clearing pass after reset.
module radix2_fft_ifft_core #(
    parameter int MAX_POINTS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic signed [15:0] i_sample_re,
    input  logic signed [15:0] i_sample_im,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_result_re,
    output logic signed [31:0] o_result_im,
    output logic [11:0]        o_bin_index,
    output logic               o_last_bin,
    output logic               o_pull_status
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int TW_AW = (AW > 1) ? AW - 1 : 1;
    localparam int LW    = $clog2(AW + 1);
    localparam int CW    = AW + 1;

    localparam logic [1:0] REG_LOG2    = 2'd0;
    localparam logic [1:0] REG_INVERSE = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE, S_PULL,
        S_BR_RI, S_BR_RR, S_BR_WI, S_BR_WR,
        S_BF_RA, S_BF_RB, S_BF_MUL, S_BF_SUM, S_BF_WA, S_BF_WB
    } t_state;

    t_state         r_state;
    logic [3:0]     r_cfg_log2;
    logic           r_cfg_inv;
    logic [LW-1:0]  r_frame_l;
    logic           r_frame_inv;
    logic [CW-1:0]  r_load_cnt;
    logic [CW-1:0]  r_read_cnt;
    logic           r_ready;
    logic [AW-1:0]  r_idx;
    logic [LW-1:0]  r_stage;
    logic [AW-1:0]  r_bf;
    logic [63:0]    r_tmp;
    logic           r_out_valid;
    logic [31:0]    r_res_re, r_res_im;
    logic [11:0]    r_bin;
    logic           r_last;
    logic           r_status;

    logic [CW-1:0]  n_load_cnt;

    logic [LW-1:0]  cur_l;
    logic [CW-1:0]  cur_n, frame_n;
    logic [AW-1:0]  frame_mask, rev_full, rev_i;
    logic [AW-1:0]  smask, jv, ia, ib, half_last;
    logic [AW-1:0]  widx_full;
    logic [TW_AW-1:0] widx;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic [63:0]    wdata, rdata;
    logic signed [15:0] tw_cos, tw_sin;
    r2fft_pkg::t_bf_ctrl bf_ctrl;
    r2fft_pkg::t_cplx    bf_sum, bf_dif;

    logic           in_acc;
    logic signed [32:0] sc_re, sc_im, rnd;
    logic [31:0]    pull_idx32;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;

    always_comb begin
        if (r_cfg_log2 == 4'd0)                 cur_l = LW'(1);
        else if ({1'b0, r_cfg_log2} > 5'(AW))   cur_l = LW'(AW);
        else                                    cur_l = LW'(r_cfg_log2);
        cur_n      = CW'(1) << cur_l;
        frame_n    = CW'(1) << r_frame_l;
        frame_mask = AW'(frame_n - CW'(1));
        n_load_cnt = r_ready ? '0 : r_load_cnt;
        if (n_load_cnt >= cur_n) n_load_cnt = '0;
    end

    // bit reversal over the latched frame length
    always_comb begin
        for (int b = 0; b < AW; b++) begin
            rev_full[b] = r_idx[AW-1-b];
        end
        rev_i = rev_full >> (LW'(AW) - r_frame_l);
    end

    always_comb begin
        smask     = AW'((CW'(1) << r_stage) - CW'(1));
        jv        = r_bf & smask;
        ia        = ((r_bf >> r_stage) << (r_stage + LW'(1))) | jv;
        ib        = ia | AW'(CW'(1) << r_stage);
        half_last = frame_mask >> 1;
        widx_full = jv << (LW'(AW - 1) - r_stage);
        widx      = widx_full[TW_AW-1:0];
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = rdata;
        raddr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                we    = in_acc && !i_operation;
                waddr = n_load_cnt[AW-1:0];
                wdata = {{16{i_sample_im[15]}}, i_sample_im,
                         {16{i_sample_re[15]}}, i_sample_re};
                raddr = r_read_cnt[AW-1:0];
            end
            S_PULL:   raddr = r_read_cnt[AW-1:0];
            S_BR_RI:  raddr = r_idx;
            S_BR_RR:  raddr = rev_i;
            S_BR_WI: begin
                we    = 1'b1;
                waddr = r_idx;
                wdata = rdata;
            end
            S_BR_WR: begin
                we    = 1'b1;
                waddr = rev_i;
                wdata = r_tmp;
            end
            S_BF_RA:  raddr = ia;
            S_BF_RB:  raddr = ib;
            S_BF_MUL, S_BF_SUM: raddr = ia;
            S_BF_WA: begin
                we    = 1'b1;
                waddr = ia;
                wdata = bf_sum;
            end
            S_BF_WB: begin
                we    = 1'b1;
                waddr = ib;
                wdata = bf_dif;
            end
            default: raddr = r_idx;
        endcase
    end

    always_comb begin
        bf_ctrl         = '0;
        bf_ctrl.load_a  = (r_state == S_BF_RB);
        bf_ctrl.mul_en  = (r_state == S_BF_MUL);
        bf_ctrl.sum_en  = (r_state == S_BF_SUM);
        bf_ctrl.bypass  = (widx == '0);
        bf_ctrl.inverse = r_frame_inv;
    end

    // rounded 1/N shift for the inverse transform
    always_comb begin
        rnd   = 33'(CW'(1) << (r_frame_l - LW'(1)));
        sc_re = ($signed({rdata[31], rdata[31:0]}) + rnd) >>> r_frame_l;
        sc_im = ($signed({rdata[63], rdata[63:32]}) + rnd) >>> r_frame_l;
        pull_idx32 = 32'(r_read_cnt);
    end

    r2fft_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    r2fft_twrom #(.MAX_POINTS(MAX_POINTS)) u_twrom (
        .i_clk  (i_clk),
        .i_addr (widx),
        .o_cos  (tw_cos),
        .o_sin  (tw_sin)
    );

    r2fft_bfly u_bfly (
        .i_clk  (i_clk),
        .i_ctrl (bf_ctrl),
        .i_data (r2fft_pkg::t_cplx'(rdata)),
        .i_cos  (tw_cos),
        .i_sin  (tw_sin),
        .o_sum  (bf_sum),
        .o_dif  (bf_dif)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_log2  <= 4'd10;
            r_cfg_inv   <= 1'b0;
            r_frame_l   <= LW'(1);
            r_frame_inv <= 1'b0;
            r_load_cnt  <= '0;
            r_read_cnt  <= '0;
            r_ready     <= 1'b0;
            r_idx       <= '0;
            r_stage     <= '0;
            r_bf        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_LOG2)    r_cfg_log2 <= i_cfg_data[3:0];
                if (i_cfg_index == REG_INVERSE) r_cfg_inv  <= i_cfg_data[0];
            end
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && !i_operation) begin
                        r_ready <= 1'b0;
                        if (n_load_cnt + CW'(1) == cur_n) begin
                            r_load_cnt  <= '0;
                            r_read_cnt  <= '0;
                            r_frame_l   <= cur_l;
                            r_frame_inv <= r_cfg_inv;
                            r_idx       <= '0;
                            r_state     <= S_BR_RI;
                        end else begin
                            r_load_cnt  <= n_load_cnt + CW'(1);
                        end
                    end else if (in_acc) begin
                        if (r_ready) begin
                            r_state <= S_PULL;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_res_re    <= '0;
                            r_res_im    <= '0;
                            r_bin       <= '0;
                            r_last      <= 1'b0;
                            r_status    <= 1'b1;
                        end
                    end
                end
                S_PULL: begin
                    r_out_valid <= 1'b1;
                    r_res_re    <= r_frame_inv ? sc_re[31:0] : rdata[31:0];
                    r_res_im    <= r_frame_inv ? sc_im[31:0] : rdata[63:32];
                    r_bin       <= pull_idx32[11:0];
                    r_last      <= (r_read_cnt + CW'(1) == frame_n);
                    r_status    <= 1'b0;
                    if (r_read_cnt + CW'(1) >= frame_n) begin
                        r_read_cnt <= '0;
                        r_ready    <= 1'b0;
                    end else begin
                        r_read_cnt <= r_read_cnt + CW'(1);
                    end
                    r_state <= S_IDLE;
                end
                S_BR_RI: begin
                    if (rev_i > r_idx) begin
                        r_state <= S_BR_RR;
                    end else if (r_idx == frame_mask) begin
                        r_stage <= '0;
                        r_bf    <= '0;
                        r_state <= S_BF_RA;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_BR_RR: begin
                    r_tmp   <= rdata;
                    r_state <= S_BR_WI;
                end
                S_BR_WI: r_state <= S_BR_WR;
                S_BR_WR: begin
                    if (r_idx == frame_mask) begin
                        r_stage <= '0;
                        r_bf    <= '0;
                        r_state <= S_BF_RA;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_BR_RI;
                    end
                end
                S_BF_RA:  r_state <= S_BF_RB;
                S_BF_RB:  r_state <= S_BF_MUL;
                S_BF_MUL: r_state <= S_BF_SUM;
                S_BF_SUM: r_state <= S_BF_WA;
                S_BF_WA:  r_state <= S_BF_WB;
                S_BF_WB: begin
                    if (r_bf == half_last) begin
                        r_bf <= '0;
                        if (r_stage == r_frame_l - LW'(1)) begin
                            r_ready <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_stage <= r_stage + LW'(1);
                            r_state <= S_BF_RA;
                        end
                    end else begin
                        r_bf    <= r_bf + AW'(1);
                        r_state <= S_BF_RA;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_re   = r_res_re;
    assign o_result_im   = r_res_im;
    assign o_bin_index   = r_bin;
    assign o_last_bin    = r_last;
    assign o_pull_status = r_status;

`ifndef NO_ASSERTIONS
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input not stalled during transform");

    a_empty_pull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_operation && !r_ready) |=> (o_out_valid && o_pull_status))
        else $error("pull with no results gave no status transaction");

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_cnt < CW'(MAX_POINTS))
        else $error("load count out of range");

    a_ready_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ready) |-> (r_load_cnt == '0 && r_read_cnt == '0))
        else $error("results flagged with counters not cleared");
`endif

endmodule

// ----- src/r2fft_ram.sv -----
module r2fft_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- src/r2fft_twrom.sv -----
module r2fft_twrom #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                                             i_clk,
    input  logic [(($clog2(MAX_POINTS) > 1) ? $clog2(MAX_POINTS) - 1 : 1)-1:0] i_addr,
    output logic signed [15:0]                               o_cos,
    output logic signed [15:0]                               o_sin
);

    localparam int AW    = ($clog2(MAX_POINTS) > 1) ? $clog2(MAX_POINTS) - 1 : 1;
    localparam int DEPTH = 1 << AW;

    typedef logic [31:0] t_rom_arr [DEPTH];

    // Q1.15 quantiser, round to nearest, symmetric about zero, clamped to +32767.
    function automatic logic [15:0] quant(input real v);
        real m;
        int  q;
        m = (v < 0.0) ? -v : v;
        q = $rtoi(m + 0.5);
        if (q > 32767) q = 32767;
        if (v < 0.0) q = -q;
        return q[15:0];
    endfunction

    function automatic t_rom_arr build_rom();
        t_rom_arr a;
        real      ang;
        for (int k = 0; k < DEPTH; k++) begin
            ang  = 2.0 * 3.14159265358979323846 * k / MAX_POINTS;
            a[k] = {quant(32768.0 * $sin(ang)), quant(32768.0 * $cos(ang))};
        end
        return a;
    endfunction

    localparam t_rom_arr ROM = build_rom();

    logic [31:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= ROM[i_addr];
    end

    assign o_cos = r_data[15:0];
    assign o_sin = r_data[31:16];

endmodule

// ----- src/r2fft_bfly.sv -----
module r2fft_bfly (
    input  logic                  i_clk,
    input  r2fft_pkg::t_bf_ctrl   i_ctrl,
    input  r2fft_pkg::t_cplx      i_data,
    input  logic signed [15:0]    i_cos,
    input  logic signed [15:0]    i_sin,
    output r2fft_pkg::t_cplx      o_sum,
    output r2fft_pkg::t_cplx      o_dif
);

    r2fft_pkg::t_cplx   r_a;
    r2fft_pkg::t_cplx   r_b;
    r2fft_pkg::t_cplx   r_t;
    logic signed [47:0] r_p0, r_p1, r_p2, r_p3;

    logic signed [48:0] pr, pim;
    logic signed [33:0] rr, ri;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return v[31:0];
    endfunction

    always_comb begin
        pr  = i_ctrl.inverse ? (49'(r_p0) - 49'(r_p1)) : (49'(r_p0) + 49'(r_p1));
        pim = i_ctrl.inverse ? (49'(r_p2) + 49'(r_p3)) : (49'(r_p2) - 49'(r_p3));
        rr  = 34'((pr + 49'sd16384) >>> 15);
        ri  = 34'((pim + 49'sd16384) >>> 15);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_a) begin
            r_a <= i_data;
        end
        if (i_ctrl.mul_en) begin
            r_b  <= i_data;
            r_p0 <= i_data.re * i_cos;
            r_p1 <= i_data.im * i_sin;
            r_p2 <= i_data.im * i_cos;
            r_p3 <= i_data.re * i_sin;
        end
        if (i_ctrl.sum_en) begin
            // unity twiddle skips the product entirely
            r_t.re <= i_ctrl.bypass ? r_b.re : sat34(rr);
            r_t.im <= i_ctrl.bypass ? r_b.im : sat34(ri);
        end
    end

    always_comb begin
        o_sum.re = sat33({r_a.re[31], r_a.re} + {r_t.re[31], r_t.re});
        o_sum.im = sat33({r_a.im[31], r_a.im} + {r_t.im[31], r_t.im});
        o_dif.re = sat33({r_a.re[31], r_a.re} - {r_t.re[31], r_t.re});
        o_dif.im = sat33({r_a.im[31], r_a.im} - {r_t.im[31], r_t.im});
    end

endmodule

// ----- tb/sv/tb_radix2_fft_ifft_core.sv -----
`timescale 1ns / 100ps

module tb_radix2_fft_ifft_core;

    localparam int MAX_PTS     = 4096;
    localparam int LOG2_MAX    = 12;
    localparam int SETTLE_CYC  = 40;
    localparam longint LIMIT   = 4000000;
    localparam int N_RANDOM    = 400;

    localparam logic       OP_PUSH   = 1'b0;
    localparam logic       OP_PULL   = 1'b1;
    localparam logic [1:0] REG_LOG2  = 2'd0;
    localparam logic [1:0] REG_INV   = 2'd1;
    localparam logic       ST_BIN    = 1'b0;
    localparam logic       ST_EMPTY  = 1'b1;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [11:0]        idx;
        logic               last;
        logic               status;
    } bin_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               operation;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] result_re;
    logic signed [31:0] result_im;
    logic [11:0]        bin_index;
    logic               last_bin;
    logic               pull_status;

    radix2_fft_ifft_core DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_operation  (operation),
        .i_sample_re  (sample_re),
        .i_sample_im  (sample_im),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_result_re  (result_re),
        .o_result_im  (result_im),
        .o_bin_index  (bin_index),
        .o_last_bin   (last_bin),
        .o_pull_status(pull_status)
    );

    // FFT state as the block should hold it
    logic signed [31:0] bins_re [MAX_PTS];
    logic signed [31:0] bins_im [MAX_PTS];
    int                 cos_q15 [MAX_PTS/2];
    int                 sin_q15 [MAX_PTS/2];
    int                 load_cnt, read_cnt, frm_log2, reg_log2;
    bit                 frame_done, frm_inv, reg_inv;

    bin_t   pending_bins[$];
    int     errors;
    int     mismatches;
    int     stall_left;
    int     hold_len;
    bit     quiet;
    longint cycles;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic int q15(real v);
        real a;
        int  m;
        a = (v < 0.0) ? -v : v;
        m = $rtoi($floor(a * 32768.0 + 0.5));
        if (m > 32767) m = 32767;
        return (v < 0.0) ? -m : m;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic fft_in_place(int lg, bit inv);
        int n, r, s, stride, w;
        int ia, ib;
        logic signed [31:0] t;
        longint ar, ai, br, bi, tr, ti, c, sn, pr, pi, half;
        n = 1 << lg;
        for (int i = 0; i < n; i++) begin
            r = 0;
            for (int b = 0; b < lg; b++) r |= ((i >> b) & 1) << (lg - 1 - b);
            if (r > i) begin
                t = bins_re[i]; bins_re[i] = bins_re[r]; bins_re[r] = t;
                t = bins_im[i]; bins_im[i] = bins_im[r]; bins_im[r] = t;
            end
        end
        for (s = 1; s < n; s = s << 1) begin
            stride = MAX_PTS / (2 * s);
            for (int k = 0; k < n; k += 2 * s) begin
                for (int j = 0; j < s; j++) begin
                    ia = k + j;
                    ib = k + j + s;
                    w  = j * stride;
                    ar = bins_re[ia]; ai = bins_im[ia];
                    br = bins_re[ib]; bi = bins_im[ib];
                    tr = br; ti = bi;
                    if (w != 0) begin
                        c  = cos_q15[w];
                        sn = sin_q15[w];
                        if (inv) begin
                            pr = br * c - bi * sn; pi = bi * c + br * sn;
                        end else begin
                            pr = br * c + bi * sn; pi = bi * c - br * sn;
                        end
                        tr = sat32((pr + 64'sd16384) >>> 15);
                        ti = sat32((pi + 64'sd16384) >>> 15);
                    end
                    bins_re[ia] = 32'(sat32(ar + tr)); bins_im[ia] = 32'(sat32(ai + ti));
                    bins_re[ib] = 32'(sat32(ar - tr)); bins_im[ib] = 32'(sat32(ai - ti));
                end
            end
        end
        if (inv) begin
            half = 64'sd1 <<< (lg - 1);
            for (int i = 0; i < n; i++) begin
                ar = bins_re[i]; ai = bins_im[i];
                bins_re[i] = 32'((ar + half) >>> lg);
                bins_im[i] = 32'((ai + half) >>> lg);
            end
        end
    endtask

    task automatic fft_accept(logic op, logic signed [15:0] re, logic signed [15:0] im);
        int   lg, n;
        bin_t b;
        if (op == OP_PUSH) begin
            lg = reg_log2;
            if (lg == 0) lg = 1;
            if (lg > LOG2_MAX) lg = LOG2_MAX;
            n = 1 << lg;
            if (frame_done) begin
                frame_done = 1'b0; read_cnt = 0; load_cnt = 0;
            end
            if (load_cnt >= n) load_cnt = 0;
            bins_re[load_cnt] = re;
            bins_im[load_cnt] = im;
            load_cnt++;
            if (load_cnt == n) begin
                frm_log2 = lg;
                frm_inv  = reg_inv;
                fft_in_place(lg, frm_inv);
                load_cnt = 0; read_cnt = 0; frame_done = 1'b1;
            end
        end else if (!frame_done) begin
            b = '{re: '0, im: '0, idx: '0, last: 1'b0, status: ST_EMPTY};
            pending_bins.push_back(b);
        end else begin
            n = 1 << frm_log2;
            b.re = bins_re[read_cnt];
            b.im = bins_im[read_cnt];
            b.idx = read_cnt[11:0];
            b.last = (read_cnt + 1 == n);
            b.status = ST_BIN;
            pending_bins.push_back(b);
            read_cnt++;
            if (read_cnt >= n) begin
                read_cnt = 0; frame_done = 1'b0;
            end
        end
    endtask

    // result checker
    always @(posedge clk) begin
        bin_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_bins.size() == 0) begin
                errors++;
                if (mismatches < 10) $display("unexpected result bin %0d", bin_index);
                mismatches++;
            end else begin
                e = pending_bins.pop_front();
                if (result_re !== e.re || result_im !== e.im || bin_index !== e.idx ||
                    last_bin !== e.last || pull_status !== e.status) begin
                    errors++;
                    if (mismatches < 10)
                        $display({"mismatch exp re=%0d im=%0d bin=%0d last=%b st=%b, ",
                                  "got re=%0d im=%0d bin=%0d last=%b st=%b"},
                                 e.re, e.im, e.idx, e.last, e.status,
                                 result_re, result_im, bin_index, last_bin, pull_status);
                    mismatches++;
                end
            end
            stall_left = quiet ? 0 : $urandom_range(0, 19);
        end
    end

    // receiver stall, including long hold-offs
    initial begin
        out_stall = 1'b1;
        forever begin
            @(negedge clk);
            if (hold_len > 0) begin
                out_stall <= 1'b1;
                hold_len--;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(logic op, logic signed [15:0] re, logic signed [15:0] im);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        sample_re <= re;
        sample_im <= im;
        do @(posedge clk); while (in_stall);
        fft_accept(op, re, im);
    endtask

    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_LOG2) reg_log2 = val[3:0];
        else if (idx == REG_INV) reg_inv = val[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        go_idle();
        while (pending_bins.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 15) - 8);
            3: return 16'($urandom_range(0, 4095) - 2048);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_frame(int n);
        for (int i = 0; i < n; i++) send_item(OP_PUSH, rand_sample(), rand_sample());
    endtask

    task automatic pull_bins(int n);
        for (int i = 0; i < n; i++) send_item(OP_PULL, 16'($urandom), 16'($urandom));
    endtask

    task automatic test_empty_pull();
        pull_bins(2);
        wait_drained();
    endtask

    task automatic test_directed();
        write_reg(REG_LOG2, 16'd2);
        write_reg(REG_INV, 16'd0);
        send_item(OP_PUSH, 16'sh7FFF, 16'sh8000);
        send_item(OP_PUSH, 16'sh8000, 16'sh7FFF);
        send_item(OP_PUSH, 16'sh7FFF, 16'sh7FFF);
        send_item(OP_PUSH, 16'sh8000, 16'sh8000);
        pull_bins(5);                  // one extra: nothing left
        wait_drained();
        write_reg(REG_INV, 16'd1);
        send_item(OP_PUSH, 16'sh7FFF, 16'sh0000);
        send_item(OP_PUSH, -16'sd1, 16'sh0001);
        send_item(OP_PUSH, 16'sh8000, 16'sh7FFF);
        send_item(OP_PUSH, 16'sh0000, 16'sh8000);
        pull_bins(4);
        wait_drained();
        // zero length behaves as two points
        write_reg(REG_LOG2, 16'd0);
        send_item(OP_PUSH, 16'sh8000, 16'sh8000);
        send_item(OP_PUSH, 16'sh7FFF, 16'sh8000);
        pull_bins(1);
        // push in the middle of readout drops the rest
        push_frame(2);
        pull_bins(2);
        wait_drained();
        // oversize length, then a shorter one leaves a stale load count
        write_reg(REG_LOG2, 16'd15);
        write_reg(REG_INV, 16'd0);
        push_frame(5);
        wait_drained();
        write_reg(REG_LOG2, 16'd2);
        push_frame(4);
        pull_bins(4);
        wait_drained();
    endtask

    task automatic test_random_frames();
        int items, lg, n, frames, kind;
        items = 0;
        frames = 0;
        while (items < N_RANDOM) begin
            lg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            write_reg(REG_LOG2, 16'(lg));
            write_reg(REG_INV, 16'($urandom_range(0, 1)));
            if (lg == 0) lg = 1;
            n = 1 << lg;
            quiet = ($urandom_range(0, 4) == 0);
            push_frame(n);
            if (frames == 3) hold_len = 400;
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                pull_bins($urandom_range(0, n - 1));
                push_frame(n);
                pull_bins(n);
            end else if (kind == 1) begin
                for (int i = 0; i < 6; i++)
                    send_item(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
                pull_bins(n + 1);
            end else begin
                pull_bins(n);
            end
            items += 2 * n;
            frames++;
            quiet = 1'b0;
            wait_drained();
        end
    endtask

    task automatic test_long_frame();
        write_reg(REG_LOG2, 16'd9);
        write_reg(REG_INV, 16'd1);
        quiet = 1'b1;
        push_frame(512);
        pull_bins(512);
        quiet = 1'b0;
        wait_drained();
        write_reg(REG_INV, 16'd0);
    endtask

    initial begin
        for (int k = 0; k < MAX_PTS / 2; k++) begin
            cos_q15[k] = q15($cos(2.0 * 3.14159265358979323846 * k / MAX_PTS));
            sin_q15[k] = q15($sin(2.0 * 3.14159265358979323846 * k / MAX_PTS));
        end
        for (int i = 0; i < MAX_PTS; i++) begin
            bins_re[i] = '0;
            bins_im[i] = '0;
        end
        load_cnt = 0; read_cnt = 0; frame_done = 1'b0;
        frm_log2 = 1; frm_inv = 1'b0; reg_log2 = 10; reg_inv = 1'b0;
        errors = 0; mismatches = 0; stall_left = 0; hold_len = 0; quiet = 1'b0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_LOG2;
        cfg_data  = '0;
        in_valid  = 1'b0;
        operation = OP_PUSH;
        sample_re = '0;
        sample_im = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_pull();
        test_directed();
        test_random_frames();
        test_long_frame();

        wait_drained();
        if (pending_bins.size() != 0) errors++;
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/r2fft_pkg.sv
src/r2fft_ram.sv
src/r2fft_twrom.sv
src/r2fft_bfly.sv
src/radix2_fft_ifft_core.sv
tb/sv/tb_radix2_fft_ifft_core.sv
